### rtl/mffr_pkg.sv
package mffr_pkg;

	typedef enum logic {
		ACT_BYTE  = 1'b0,
		ACT_REARM = 1'b1
	} action_t;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam int unsigned BYTE_BITS = 8;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < BYTE_BITS; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### rtl/modbus_fixed_frame_receiver.sv
// Channel  Dir  tdata                     tuser
// s_axis   in   [7:0] rx_byte             [0] action (0 byte, 1 rearm)
// m_axis   out  [31:0] position_value     [0] crc_match
//
// One transaction per cycle unless a final frame byte waits on m_axis.
// CRC-16 update is combinational; a result passes s1 and the output register.
// Reset leaves the receiver armed, the count at zero and the latch at zero.
// A stalled m_axis holds only a final frame byte; other transactions proceed.
module modbus_fixed_frame_receiver #(
	parameter int FRAME_BYTES = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] position_value
	output logic        m_tuser    // [0] crc_match
);

	localparam int STORE_N = FRAME_BYTES - 1;
	localparam int CNT_W = $clog2(FRAME_BYTES);
	localparam int IDX_W = $clog2(STORE_N);
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);
	localparam logic [CNT_W-1:0] CRC_LO_IDX = CNT_W'(FRAME_BYTES - 2);

	logic                  valid_s1;
	mffr_pkg::action_t     act_s1;
	logic [7:0]            byte_s1;

	logic [CNT_W-1:0]      cnt_q;
	logic                  armed_q;
	logic [15:0]           crc_q;
	logic [31:0]           pos_q;
	logic [7:0]            store_q [STORE_N];

	logic                  out_valid_q;
	logic                  out_match_q;
	logic [31:0]           out_pos_q;

	logic                  is_byte;
	logic                  is_last;
	logic                  stall;
	logic                  adv;
	logic                  match;
	logic [31:0]           new_pos;

	always_comb begin
		is_byte = valid_s1 && (act_s1 == mffr_pkg::ACT_BYTE) && armed_q;
		is_last = is_byte && (cnt_q == LAST_IDX);
		stall   = is_last && out_valid_q && !m_tready;
		adv     = valid_s1 && !stall;
		match   = (store_q[CRC_LO_IDX[IDX_W-1:0]] == crc_q[7:0]) && (byte_s1 == crc_q[15:8]);
		new_pos = {store_q[3], store_q[4], store_q[5], store_q[6]};
	end

	assign s_tready = !valid_s1 || !stall;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pos_q;
	assign m_tuser  = out_match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_s1  <= mffr_pkg::action_t'(s_tuser);
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			armed_q     <= 1'b1;
			crc_q       <= mffr_pkg::CRC_INIT;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && !(adv && is_last)) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				if (act_s1 == mffr_pkg::ACT_REARM) begin
					armed_q <= 1'b1;
				end else if (armed_q) begin
					if (cnt_q != LAST_IDX) begin
						if (cnt_q < CRC_LO_IDX) begin
							crc_q <= mffr_pkg::crc16_byte(crc_q, byte_s1);
						end
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						if (match) begin
							pos_q <= new_pos;
						end
						armed_q     <= 1'b0;
						cnt_q       <= '0;
						crc_q       <= mffr_pkg::CRC_INIT;
						out_valid_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_byte) begin
			if (cnt_q != LAST_IDX) begin
				store_q[cnt_q[IDX_W-1:0]] <= byte_s1;
			end else begin
				out_match_q <= match;
				out_pos_q   <= match ? new_pos : pos_q;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LAST_IDX)
		else $error("frame byte count out of range");

	a_disarmed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> (cnt_q == '0) && (crc_q == mffr_pkg::CRC_INIT))
		else $error("disarmed with frame in progress");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && is_last) |=> m_tvalid && !armed_q && (cnt_q == '0))
		else $error("frame end did not emit and disarm");

	a_pos_latch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == pos_q))
		else $error("result position differs from latch");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(pos_q))
		else $error("latch changed while result pending");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int FRAME_LEN = 9;

	typedef struct packed {
		logic        crc_match;
		logic [31:0] position_value;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
	logic        s_tuser = 1'b0;    // [0] action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // [31:0] position_value
	logic        m_tuser;           // [0] crc_match

	bit          idle_en = 1'b1;
	int          stall_left = 0;
	int          mismatches = 0;

	logic [3:0]  rx_count;
	logic        rx_armed;
	logic [15:0] rx_crc;
	logic [7:0]  rx_store [FRAME_LEN - 1];
	logic [31:0] rx_position;

	frame_result_t expected_frames [$];

	modbus_fixed_frame_receiver #(
		.FRAME_BYTES(FRAME_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_en || r < 50) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 20);
	endfunction

	function automatic logic [15:0] crc16_modbus_next(input logic [15:0] acc, input logic [7:0] data);
		logic [15:0] r;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			if (r[0] ^ data[i]) begin
				r = {1'b0, r[15:1]} ^ mffr_pkg::CRC_POLY;
			end else begin
				r = {1'b0, r[15:1]};
			end
		end
		return r;
	endfunction

	task automatic predict_receiver(input mffr_pkg::action_t act, input logic [7:0] b);
		frame_result_t res;
		if (act == mffr_pkg::ACT_REARM) begin
			rx_armed = 1'b1;
		end else if (rx_armed) begin
			if (rx_count < FRAME_LEN - 1) begin
				rx_store[rx_count[2:0]] = b;
				if (rx_count < FRAME_LEN - 2) begin
					rx_crc = crc16_modbus_next(rx_crc, b);
				end
				rx_count = rx_count + 4'd1;
			end else begin
				res.crc_match = (rx_store[FRAME_LEN - 2] == rx_crc[7:0]) && (b == rx_crc[15:8]);
				if (res.crc_match) begin
					rx_position = {rx_store[3], rx_store[4], rx_store[5], rx_store[6]};
				end
				res.position_value = rx_position;
				rx_armed = 1'b0;
				rx_count = '0;
				rx_crc = mffr_pkg::CRC_INIT;
				expected_frames.push_back(res);
			end
		end
	endtask

	task automatic send_item(input mffr_pkg::action_t act, input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		predict_receiver(act, b);
	endtask

	// body byte i sits at body[8*i +: 8]; bad_idx < 0 leaves the frame intact
	task automatic send_frame(input logic [55:0] body, input int bad_idx, input int bad_bit);
		logic [71:0] frame;
		logic [15:0] crc;
		crc = mffr_pkg::CRC_INIT;
		for (int i = 0; i < FRAME_LEN - 2; i++) begin
			crc = crc16_modbus_next(crc, body[8 * i +: 8]);
		end
		frame = {crc[15:8], crc[7:0], body};
		if (bad_idx >= 0) begin
			frame[8 * bad_idx + bad_bit] = ~frame[8 * bad_idx + bad_bit];
		end
		for (int i = 0; i < FRAME_LEN; i++) begin
			send_item(mffr_pkg::ACT_BYTE, frame[8 * i +: 8]);
		end
		send_item(mffr_pkg::ACT_REARM, 8'($urandom));
	endtask

	function automatic logic [55:0] random_body();
		return 56'({$urandom, $urandom});
	endfunction

	// finish any partial frame so the next one starts aligned
	task automatic realign_frames();
		if (!rx_armed) begin
			send_item(mffr_pkg::ACT_REARM, 8'h00);
		end
		while (rx_count != 0) begin
			send_item(mffr_pkg::ACT_BYTE, 8'($urandom));
		end
		send_item(mffr_pkg::ACT_REARM, 8'h00);
	endtask

	task automatic test_directed();
		send_item(mffr_pkg::ACT_REARM, 8'hA5);
		send_frame({32'hFFFF_FFFF, 8'h04, 8'h03, 8'h01}, -1, 0);
		send_item(mffr_pkg::ACT_BYTE, 8'hFF);
		send_item(mffr_pkg::ACT_REARM, 8'h00);
		send_frame(56'h0, FRAME_LEN - 2, 0);
	endtask

	task automatic test_valid_frames();
		send_frame(56'h0, -1, 0);
		for (int n = 0; n < 100; n++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(mffr_pkg::ACT_BYTE, 8'($urandom));
				send_item(mffr_pkg::ACT_REARM, 8'($urandom));
			end
			send_frame(random_body(), -1, 0);
		end
	endtask

	task automatic test_corrupt_frames();
		send_frame(random_body(), FRAME_LEN - 1, $urandom_range(0, 7));
		for (int n = 0; n < 40; n++) begin
			send_frame(random_body(), $urandom_range(0, FRAME_LEN - 1), $urandom_range(0, 7));
		end
	endtask

	task automatic test_noise();
		for (int n = 0; n < 300; n++) begin
			send_item(($urandom_range(0, 3) == 0) ? mffr_pkg::ACT_REARM : mffr_pkg::ACT_BYTE,
				8'($urandom));
		end
		realign_frames();
	endtask

	task automatic test_back_to_back();
		idle_en = 1'b0;
		for (int n = 0; n < 15; n++) begin
			send_frame(random_body(), ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8) : -1,
				$urandom_range(0, 7));
		end
		idle_en = 1'b1;
	endtask

	always @(posedge clk) begin
		if (!idle_en) begin
			m_tready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0) begin
				stall_left <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: crc_match=%0b position_value=%08h", m_tuser, m_tdata);
				end
			end else begin
				want = expected_frames.pop_front();
				if (m_tuser !== want.crc_match || m_tdata !== want.position_value) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: crc_match exp %0b got %0b, position_value exp %08h got %08h",
							want.crc_match, m_tuser, want.position_value, m_tdata);
					end
				end
			end
		end
	end

	initial begin
		rx_count = '0;
		rx_armed = 1'b1;
		rx_crc = mffr_pkg::CRC_INIT;
		rx_position = '0;
		foreach (rx_store[i]) rx_store[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_valid_frames();
		test_corrupt_frames();
		test_noise();
		test_back_to_back();
		s_tvalid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_frames.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
